/* src/gpio_rc_pkg.sv */
// ----------------------------------------------------------------------------
// GPIO register controller package
// Word types, register map offsets and field codes shared by the block.
// ----------------------------------------------------------------------------
package gpio_rc_pkg;

	localparam int DATA_W     = 32;
	localparam int OFS_W      = 6;
	localparam int PAD_W      = 54;
	localparam int FUNC_BITS  = 3;
	localparam int PULL_BITS  = 2;
	localparam int FSEL_WORDS = 6;
	localparam int FSEL_SLOTS = 10;
	localparam int FSEL_IDX_W = 3;

	// Access modes
	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// Register map, word offsets
	localparam logic [OFS_W-1:0] OFS_FSEL_FIRST = 6'd0;
	localparam logic [OFS_W-1:0] OFS_FSEL_LAST  = 6'd5;
	localparam logic [OFS_W-1:0] OFS_SET0       = 6'd7;
	localparam logic [OFS_W-1:0] OFS_SET1       = 6'd8;
	localparam logic [OFS_W-1:0] OFS_CLR0       = 6'd10;
	localparam logic [OFS_W-1:0] OFS_CLR1       = 6'd11;
	localparam logic [OFS_W-1:0] OFS_LEV0       = 6'd13;
	localparam logic [OFS_W-1:0] OFS_LEV1       = 6'd14;
	localparam logic [OFS_W-1:0] OFS_PUD        = 6'd37;
	localparam logic [OFS_W-1:0] OFS_PUDCLK0    = 6'd38;
	localparam logic [OFS_W-1:0] OFS_PUDCLK1    = 6'd39;

	// Field codes
	localparam logic [FUNC_BITS-1:0] FUNC_OUTPUT = 3'd1;
	localparam logic [PULL_BITS-1:0] PULL_DOWN   = 2'd1;
	localparam logic [PULL_BITS-1:0] PULL_UP     = 2'd2;

	typedef struct packed {
		logic              mode;
		logic [OFS_W-1:0]  word_offset;
		logic [DATA_W-1:0] write_data;
		logic [PAD_W-1:0]  pad_levels;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [PAD_W-1:0]  output_levels;
		logic [PAD_W-1:0]  drive_enable;
		logic [PAD_W-1:0]  pull_up_mask;
		logic [PAD_W-1:0]  pull_down_mask;
	} rsp_t;

	// Offset decode
	typedef struct packed {
		logic                  fsel_hit;
		logic [FSEL_IDX_W-1:0] fsel_word;
		logic                  set_hit;
		logic                  clr_hit;
		logic                  lev_hit;
		logic                  pud_hit;
		logic                  pudclk_hit;
		logic                  hi;        // upper 32-pin half
	} dec_t;

endpackage

/* src/gpio_rc_decode.sv */
// ----------------------------------------------------------------------------
// GPIO register controller offset decode
// Maps a word offset onto register group hits and the pin half it covers.
// ----------------------------------------------------------------------------
module gpio_rc_decode (
	input  logic [gpio_rc_pkg::OFS_W-1:0] word_offset,
	output gpio_rc_pkg::dec_t             dec
);
	import gpio_rc_pkg::*;

	always_comb begin
		dec = '0;
		if (word_offset <= OFS_FSEL_LAST) begin
			dec.fsel_hit  = 1'b1;
			dec.fsel_word = FSEL_IDX_W'(word_offset - OFS_FSEL_FIRST);
		end
		case (word_offset)
			OFS_SET0: begin
				dec.set_hit = 1'b1;
			end
			OFS_SET1: begin
				dec.set_hit = 1'b1;
				dec.hi      = 1'b1;
			end
			OFS_CLR0: begin
				dec.clr_hit = 1'b1;
			end
			OFS_CLR1: begin
				dec.clr_hit = 1'b1;
				dec.hi      = 1'b1;
			end
			OFS_LEV0: begin
				dec.lev_hit = 1'b1;
			end
			OFS_LEV1: begin
				dec.lev_hit = 1'b1;
				dec.hi      = 1'b1;
			end
			OFS_PUD: begin
				dec.pud_hit = 1'b1;
			end
			OFS_PUDCLK0: begin
				dec.pudclk_hit = 1'b1;
			end
			OFS_PUDCLK1: begin
				dec.pudclk_hit = 1'b1;
				dec.hi         = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/gpio_rc_regs.sv */
// ----------------------------------------------------------------------------
// GPIO register controller register file
// Pin state, access update and the response word for one bus access.
// ----------------------------------------------------------------------------
module gpio_rc_regs #(
	parameter int NUM_PINS = 54
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  gpio_rc_pkg::req_t req,
	output gpio_rc_pkg::rsp_t rsp
);
	import gpio_rc_pkg::*;

	localparam int NP = NUM_PINS;

	dec_t dec;
	logic wr;
	logic we;

	logic [FUNC_BITS-1:0] fsel_q [NP];
	logic [FUNC_BITS-1:0] fsel_d [NP];
	logic [PULL_BITS-1:0] pull_q [NP];
	logic [PULL_BITS-1:0] pull_d [NP];
	logic [NP-1:0]        latch_q;
	logic [NP-1:0]        latch_d;
	logic [PULL_BITS-1:0] pud_q;
	logic [PULL_BITS-1:0] pud_d;

	logic [NP-1:0]    drv;
	logic [NP-1:0]    up;
	logic [NP-1:0]    dn;
	logic [PAD_W-1:0] lat_o;
	logic [PAD_W-1:0] drv_o;
	logic [PAD_W-1:0] up_o;
	logic [PAD_W-1:0] dn_o;

	logic [FSEL_WORDS-1:0][FSEL_SLOTS*FUNC_BITS-1:0] fsel_rd;
	logic [2*DATA_W-1:0] lev;
	logic [DATA_W-1:0]   rdata;

	gpio_rc_decode u_decode (
		.word_offset (req.word_offset),
		.dec         (dec)
	);

	assign wr    = (req.mode == MODE_WRITE);
	assign we    = en && wr;
	assign pud_d = (we && dec.pud_hit) ? req.write_data[PULL_BITS-1:0] : pud_q;

	// Per-pin next state
	for (genvar p = 0; p < NP; p++) begin : g_pin
		localparam int W = p / FSEL_SLOTS;
		localparam int S = p % FSEL_SLOTS;
		localparam int B = p % DATA_W;
		localparam logic H = (p >= DATA_W);

		logic half_ok;
		logic fsel_we;

		assign half_ok = (dec.hi == H) && req.write_data[B];

		if (W < FSEL_WORDS) begin : g_fsel
			assign fsel_we = we && dec.fsel_hit && (dec.fsel_word == FSEL_IDX_W'(W));
		end else begin : g_nofsel
			assign fsel_we = 1'b0;
		end

		assign fsel_d[p] = fsel_we ? req.write_data[FUNC_BITS*S +: FUNC_BITS] : fsel_q[p];
		assign latch_d[p] = (we && dec.set_hit && half_ok) ? 1'b1 :
			(we && dec.clr_hit && half_ok) ? 1'b0 : latch_q[p];
		assign pull_d[p] = (we && dec.pudclk_hit && half_ok) ? pud_q : pull_q[p];

		assign drv[p] = (fsel_d[p] == FUNC_OUTPUT);
		assign up[p]  = (pull_d[p] == PULL_UP);
		assign dn[p]  = (pull_d[p] == PULL_DOWN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			pud_q   <= '0;
			for (int i = 0; i < NP; i++) begin
				fsel_q[i] <= '0;
				pull_q[i] <= '0;
			end
		end else begin
			latch_q <= latch_d;
			pud_q   <= pud_d;
			for (int i = 0; i < NP; i++) begin
				fsel_q[i] <= fsel_d[i];
				pull_q[i] <= pull_d[i];
			end
		end
	end

	// Select words as read, absent pins read zero
	for (genvar w = 0; w < FSEL_WORDS; w++) begin : g_rdw
		for (genvar s = 0; s < FSEL_SLOTS; s++) begin : g_rds
			if (w * FSEL_SLOTS + s < NP) begin : g_on
				assign fsel_rd[w][FUNC_BITS*s +: FUNC_BITS] = fsel_q[w * FSEL_SLOTS + s];
			end else begin : g_off
				assign fsel_rd[w][FUNC_BITS*s +: FUNC_BITS] = '0;
			end
		end
	end

	// Pad levels of present pins
	for (genvar b = 0; b < 2 * DATA_W; b++) begin : g_lev
		if (b < NP && b < PAD_W) begin : g_on
			assign lev[b] = req.pad_levels[b];
		end else begin : g_off
			assign lev[b] = 1'b0;
		end
	end

	// Pin-facing outputs, pins 0..PAD_W-1 only
	for (genvar b = 0; b < PAD_W; b++) begin : g_out
		if (b < NP) begin : g_on
			assign lat_o[b] = latch_d[b];
			assign drv_o[b] = drv[b];
			assign up_o[b]  = up[b];
			assign dn_o[b]  = dn[b];
		end else begin : g_off
			assign lat_o[b] = 1'b0;
			assign drv_o[b] = 1'b0;
			assign up_o[b]  = 1'b0;
			assign dn_o[b]  = 1'b0;
		end
	end

	always_comb begin
		rdata = '0;
		if (!wr) begin
			if (dec.fsel_hit) begin
				rdata = {{(DATA_W - FSEL_SLOTS*FUNC_BITS){1'b0}}, fsel_rd[dec.fsel_word]};
			end else if (dec.lev_hit) begin
				rdata = dec.hi ? lev[2*DATA_W-1:DATA_W] : lev[DATA_W-1:0];
			end else if (dec.pud_hit) begin
				rdata = {{(DATA_W - PULL_BITS){1'b0}}, pud_q};
			end
		end
	end

	always_comb begin
		rsp.read_data      = rdata;
		rsp.output_levels  = lat_o;
		rsp.drive_enable   = drv_o;
		rsp.pull_up_mask   = up_o;
		rsp.pull_down_mask = dn_o;
	end

endmodule

/* src/gpio_register_controller_top.sv */
// ----------------------------------------------------------------------------
// GPIO register controller, top level
// Word-addressed GPIO register block: function select, set/clear output
// latch, pad level read-back and clocked pull configuration per pin.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | word   | carries
//   --------+----------------------+--------+----------------------------------
//   req     | req_valid/req_stall  | req_t  | one bus access plus pad levels
//   rsp     | rsp_valid/rsp_stall  | rsp_t  | read data and pin state after it
//
// Cycles: one word per clock sustained while rsp_stall is low; each word passes the
//   input register, then result register; access decode and pin update sit between.
// State changes when a word moves from the input register to the result
//   register, so accesses apply strictly in order.
// Reset: arst_n clears all pin state to its idle values and empties both
//   registers.
// Stalls: req_stall rises only when both registers hold words and rsp_stall
//   is high; the input register keeps its word until the result slot frees.
// ----------------------------------------------------------------------------
module gpio_register_controller_top #(
	parameter int NUM_PINS = 54
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  gpio_rc_pkg::req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output gpio_rc_pkg::rsp_t rsp
);
	import gpio_rc_pkg::*;

	// input register
	logic valid_s1;
	req_t req_s1;

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic adv;      // word leaves the input register this cycle
	rsp_t rsp_d;

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	gpio_rc_regs #(
		.NUM_PINS (NUM_PINS)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.req    (req_s1),
		.rsp    (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid_q)
		else $error("result register not loaded after advance");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1.mode == MODE_WRITE |=> rsp_q.read_data == '0)
		else $error("write access returned nonzero read data");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1))
		else $error("input register lost a held word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid_q && rsp_stall)
		else $error("input stalled while result slot free");
`endif

endmodule

/* bench/gpio_rc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPIO register controller checker
// Watches the access and result channels, keeps its own copy of the pin
// state, predicts one result word per access and compares field by field.
// ----------------------------------------------------------------------------
module gpio_rc_checker #(
	parameter int NUM_PINS = 54
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  gpio_rc_pkg::req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  gpio_rc_pkg::rsp_t rsp,
	output int                fail_count,
	output int                outstanding,
	output int                checked
);
	import gpio_rc_pkg::*;

	// mirrored pin state
	logic [FUNC_BITS-1:0] fsel_m [64];
	logic [63:0]          latch_m;
	logic [PULL_BITS-1:0] pud_m;
	logic [PULL_BITS-1:0] pull_m [64];

	rsp_t pending_rsp [$];
	rsp_t want;

	function automatic logic [63:0] to_pins(input logic [DATA_W-1:0] w, input logic hi);
		return hi ? {w, 32'd0} : {32'd0, w};
	endfunction

	// applies one access to the mirror, returns the result word it should produce
	function automatic rsp_t apply_access(input req_t a);
		rsp_t              r;
		logic [63:0]       pins;
		logic [63:0]       pads;
		logic [63:0]       mask;
		logic [DATA_W-1:0] rd;
		logic              wr;
		int                p;
		pins = (NUM_PINS >= 64) ? '1 : ((64'd1 << NUM_PINS) - 64'd1);
		pads = {{(64-PAD_W){1'b0}}, a.pad_levels} & pins;
		wr   = (a.mode == MODE_WRITE);
		rd   = '0;
		if (a.word_offset <= OFS_FSEL_LAST) begin
			for (int i = 0; i < FSEL_SLOTS; i++) begin
				p = int'(a.word_offset) * FSEL_SLOTS + i;
				if (p < NUM_PINS) begin
					if (wr)
						fsel_m[p] = a.write_data[FUNC_BITS*i +: FUNC_BITS];
					else
						rd[FUNC_BITS*i +: FUNC_BITS] = fsel_m[p];
				end
			end
		end else if (a.word_offset == OFS_SET0 || a.word_offset == OFS_SET1) begin
			if (wr)
				latch_m |= to_pins(a.write_data, a.word_offset == OFS_SET1) & pins;
		end else if (a.word_offset == OFS_CLR0 || a.word_offset == OFS_CLR1) begin
			if (wr)
				latch_m &= ~(to_pins(a.write_data, a.word_offset == OFS_CLR1) & pins);
		end else if (a.word_offset == OFS_LEV0 || a.word_offset == OFS_LEV1) begin
			if (!wr)
				rd = (a.word_offset == OFS_LEV1) ? pads[63:32] : pads[31:0];
		end else if (a.word_offset == OFS_PUD) begin
			if (wr)
				pud_m = a.write_data[PULL_BITS-1:0];
			else
				rd = {{(DATA_W-PULL_BITS){1'b0}}, pud_m};
		end else if (a.word_offset == OFS_PUDCLK0 || a.word_offset == OFS_PUDCLK1) begin
			if (wr) begin
				mask = to_pins(a.write_data, a.word_offset == OFS_PUDCLK1) & pins;
				for (int i = 0; i < 64; i++)
					if (mask[i])
						pull_m[i] = pud_m;
			end
		end

		r = '0;
		r.read_data     = wr ? '0 : rd;
		r.output_levels = latch_m[PAD_W-1:0] & pins[PAD_W-1:0];
		for (int i = 0; i < PAD_W; i++) begin
			if (i < NUM_PINS) begin
				r.drive_enable[i]   = (fsel_m[i] == FUNC_OUTPUT);
				r.pull_up_mask[i]   = (pull_m[i] == PULL_UP);
				r.pull_down_mask[i] = (pull_m[i] == PULL_DOWN);
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want_v, got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	// results are popped before the same edge's access is pushed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) begin
				fsel_m[i] = '0;
				pull_m[i] = '0;
			end
			latch_m = '0;
			pud_m   = '0;
			pending_rsp.delete();
			fail_count  = 0;
			outstanding = 0;
			checked     = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: result word with none expected, got %h", $time, rsp);
					fail_count++;
				end else begin
					want = pending_rsp.pop_front();
					check_field("read_data", 64'(want.read_data), 64'(rsp.read_data));
					check_field("output_levels", 64'(want.output_levels),
						64'(rsp.output_levels));
					check_field("drive_enable", 64'(want.drive_enable),
						64'(rsp.drive_enable));
					check_field("pull_up_mask", 64'(want.pull_up_mask),
						64'(rsp.pull_up_mask));
					check_field("pull_down_mask", 64'(want.pull_down_mask),
						64'(rsp.pull_down_mask));
					checked++;
				end
			end
			if (req_valid && !req_stall)
				pending_rsp.push_back(apply_access(req));
			outstanding = pending_rsp.size();
		end
	end

endmodule

/* bench/tb_gpio_register_controller_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPIO register controller testbench
// Drives bus access words into the block, stalls the result side at random,
// and lets the checker score every result word against its own pin model.
// ----------------------------------------------------------------------------
module tb_gpio_register_controller_top;
	import gpio_rc_pkg::*;

	localparam int PINS        = 54;
	localparam int IDLE_LIMIT  = 2000;   // cycles with no word moving on either side
	localparam int HOLD_CYCLES = 80;     // long result-side hold-off

	// offsets with nothing behind them
	localparam logic [OFS_W-1:0] OFS_HOLE     = 6'd6;
	localparam logic [OFS_W-1:0] OFS_PAST_PUD = 6'd40;
	localparam logic [OFS_W-1:0] OFS_LAST     = 6'd63;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int fail_count;
	int outstanding;
	int checked;

	int sent        = 0;
	int reads       = 0;
	int writes      = 0;
	int pull_seqs   = 0;
	int stall_left  = 0;
	int idle_cycles = 0;
	bit gaps_on     = 1'b0;   // sender idles between words
	bit stall_on    = 1'b0;   // receiver stalls at random
	bit hold_rsp    = 1'b0;   // one long receiver hold-off, cleared by the receiver

	gpio_register_controller_top #(
		.NUM_PINS(PINS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	gpio_rc_checker #(
		.NUM_PINS(PINS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.checked(checked)
	);

	// 20 ns clock, rising edge at time zero
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [PAD_W-1:0] rand_pads();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[PAD_W-1:0];
	endfunction

	function automatic req_t make_access(input logic m, input logic [OFS_W-1:0] o,
			input logic [DATA_W-1:0] d, input logic [PAD_W-1:0] p);
		req_t a;
		a.mode        = m;
		a.word_offset = o;
		a.write_data  = d;
		a.pad_levels  = p;
		return a;
	endfunction

	// single access, weighted toward the mapped words; three in ten hit any offset
	function automatic req_t rand_access();
		logic [OFS_W-1:0] o;
		logic             m;
		m = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
		case ($urandom_range(0, 9))
			0, 1: o = OFS_W'($urandom_range(0, FSEL_WORDS - 1));
			2: o = $urandom_range(0, 1) ? OFS_SET1 : OFS_SET0;
			3: o = $urandom_range(0, 1) ? OFS_CLR1 : OFS_CLR0;
			4: o = $urandom_range(0, 1) ? OFS_LEV1 : OFS_LEV0;
			5: o = OFS_PUD;
			6: o = $urandom_range(0, 1) ? OFS_PUDCLK1 : OFS_PUDCLK0;
			default: o = OFS_W'($urandom_range(0, 63));
		endcase
		return make_access(m, o, $urandom, rand_pads());
	endfunction

	// Present one word at the falling edge and hold it until the block takes it.
	// req_stall is read right after the rising edge, before the block's registers
	// update. Valid is only lowered when a gap follows, so it never toggles twice
	// in one step.
	task automatic send_word(input req_t w);
		int g;
		req       <= w;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		sent++;
		if (w.mode == MODE_WRITE)
			writes++;
		else
			reads++;
		@(negedge clk);
		g = gaps_on ? pick_gap() : 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// usual driver flow: set pull control, clock it into a pin mask, release the clock
	task automatic pull_sequence();
		logic hi;
		hi = 1'($urandom_range(0, 1));
		send_word(make_access(MODE_WRITE, OFS_PUD, $urandom, rand_pads()));
		send_word(make_access(MODE_WRITE, hi ? OFS_PUDCLK1 : OFS_PUDCLK0,
			$urandom & $urandom, rand_pads()));
		send_word(make_access(MODE_WRITE, hi ? OFS_PUDCLK1 : OFS_PUDCLK0, '0, rand_pads()));
		pull_seqs++;
	endtask

	// read of a select word, then a write of random data with one slot set to output
	task automatic fsel_update();
		logic [OFS_W-1:0]  w;
		logic [DATA_W-1:0] d;
		w = OFS_W'($urandom_range(0, FSEL_WORDS - 1));
		d = $urandom;
		d[FUNC_BITS*$urandom_range(0, FSEL_SLOTS - 1) +: FUNC_BITS] = FUNC_OUTPUT;
		send_word(make_access(MODE_READ, w, $urandom, rand_pads()));
		send_word(make_access(MODE_WRITE, w, d, rand_pads()));
	endtask

	task automatic random_run(input int n);
		int start;
		int r;
		start = sent;
		while (sent - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				pull_sequence();
			else if (r < 25)
				fsel_update();
			else
				send_word(rand_access());
		end
	endtask

	// sender stops until every expected result word has come back
	task automatic drain();
		req_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	// Result side: long hold-off on request, otherwise random stall stretches
	// while stall_on is set.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
				rsp_stall <= 1'b0;
			end else if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				if (stall_on && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Watchdog: ends the run once idle_cycles, counting edges with no word moving, reaches IDLE_LIMIT.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("gpio_register_controller_top verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		req_valid = 1'b0;
		req       = '0;
		arst_n    = 1'b0;
		// reset spans the rising edges through 60 ns
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words: reset readback, reserved select bits, absent pins in
		// the last select word and the upper set/clear/level halves, write-only
		// and read-only words, the reserved pull code, unmapped offsets.
		send_word(make_access(MODE_READ, OFS_FSEL_FIRST, '0, '0));
		send_word(make_access(MODE_WRITE, OFS_FSEL_FIRST, '1, '0));
		send_word(make_access(MODE_READ, OFS_FSEL_FIRST, '0, '1));
		send_word(make_access(MODE_WRITE, OFS_FSEL_LAST, '1, '0));
		send_word(make_access(MODE_READ, OFS_FSEL_LAST, '1, '0));
		send_word(make_access(MODE_WRITE, OFS_FSEL_FIRST + 6'd1, 32'h0924_9249, '0));
		send_word(make_access(MODE_WRITE, OFS_SET0, '1, '0));
		send_word(make_access(MODE_WRITE, OFS_SET1, '1, '0));
		send_word(make_access(MODE_READ, OFS_SET0, '1, '1));
		send_word(make_access(MODE_WRITE, OFS_CLR0, 32'h5555_5555, '0));
		send_word(make_access(MODE_WRITE, OFS_CLR1, '1, '0));
		send_word(make_access(MODE_READ, OFS_LEV0, '0, '1));
		send_word(make_access(MODE_READ, OFS_LEV1, '0, '1));
		send_word(make_access(MODE_READ, OFS_LEV1, '1, '0));
		send_word(make_access(MODE_WRITE, OFS_LEV0, '1, '1));
		send_word(make_access(MODE_WRITE, OFS_PUD, 32'd3, '0));
		send_word(make_access(MODE_WRITE, OFS_PUDCLK0, '1, '0));
		send_word(make_access(MODE_WRITE, OFS_PUD, 32'd2, '0));
		send_word(make_access(MODE_WRITE, OFS_PUDCLK1, '1, '0));
		send_word(make_access(MODE_WRITE, OFS_PUD, 32'hFFFF_FFFD, '0));
		send_word(make_access(MODE_READ, OFS_PUD, '0, '0));
		send_word(make_access(MODE_WRITE, OFS_PUDCLK0, 32'h0000_FFFF, '0));
		send_word(make_access(MODE_READ, OFS_PUDCLK1, '0, '1));
		send_word(make_access(MODE_READ, OFS_LAST, '1, '1));
		send_word(make_access(MODE_WRITE, OFS_LAST, '1, '1));
		send_word(make_access(MODE_WRITE, OFS_HOLE, '1, '0));
		send_word(make_access(MODE_READ, OFS_PAST_PUD, '0, '0));
		drain();

		// back-to-back words, receiver never stalls
		random_run(300);

		// idling on both sides
		gaps_on  = 1'b1;
		stall_on = 1'b1;
		random_run(500);
		drain();

		// long receiver hold-off while the sender keeps offering words,
		// so both registers fill and req_stall rises
		gaps_on  = 1'b0;
		stall_on = 1'b0;
		hold_rsp = 1'b1;
		random_run(120);

		gaps_on  = 1'b1;
		stall_on = 1'b1;
		random_run(600);
		req_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (4) @(posedge clk);

		$display("Ran %0d bus accesses (%0d reads, %0d writes); %0d result words checked.",
			sent, reads, writes, checked);
		$display("Covered %0d pull programming sequences, a %0d-cycle result hold-off and drains.",
			pull_seqs, HOLD_CYCLES);
		if (fail_count == 0 && outstanding == 0)
			$display("gpio_register_controller_top verification clean");
		else
			$display("gpio_register_controller_top verification failed");
		$finish;
	end

endmodule

/* gpio_register_controller_top.f */
src/gpio_rc_pkg.sv
src/gpio_rc_decode.sv
src/gpio_rc_regs.sv
src/gpio_register_controller_top.sv
bench/gpio_rc_checker.sv
bench/tb_gpio_register_controller_top.sv
